// File: src/vb2h_pkg.sv
`default_nettype none
package vb2h_pkg;

    localparam int EDGE_DEPTH = 32;
    localparam int EDGE_AW    = 5;
    localparam int CELL_DEPTH = 1024;
    localparam int CELL_AW    = 10;
    localparam int CELL_CW    = CELL_AW + 1;
    localparam int COORD_W    = 32;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 6;
    localparam int SLOT_W     = 10;
    localparam int FUNC_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [FUNC_W-1:0] FN_LOAD_X  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD_Y  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FILL    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SET_ALL = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED  = 2'd3;

    localparam logic REG_X_COUNT = 1'b0;
    localparam logic REG_Y_COUNT = 1'b1;

endpackage
`default_nettype wire

// File: src/vb2h_if.sv
`default_nettype none
interface vb2h_cmd_if import vb2h_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] edge_value;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] weight;

    modport source (output valid, func, slot, edge_value, x_coord, y_coord, weight,
                    input ready);
    modport sink (input valid, func, slot, edge_value, x_coord, y_coord, weight,
                  output ready);
endinterface

interface vb2h_rsp_if import vb2h_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [CELL_AW-1:0]      cell_index;
    logic signed [SUM_W-1:0] cell_value;

    modport source (output valid, status, cell_index, cell_value, input ready);
    modport sink (input valid, status, cell_index, cell_value, output ready);
endinterface
`default_nettype wire

// File: src/variable_bin_2d_histogram_core.sv
// Flow: one transfer at a time, the next taken once the result is registered for the response
// channel (the x and y searches run in parallel).
// A new transfer is taken while an earlier result still waits on the response channel.
// Reset: asynchronous, active low; edge counts return to 2 and the cell store is swept to
// zero, during which no transfer is taken (configuration writes are).
`default_nettype none
module variable_bin_2d_histogram_core import vb2h_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    vb2h_cmd_if.sink                cmd,
    vb2h_rsp_if.source              rsp
);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_BOUND_LO = 11'b00000000100,
        S_BOUND_HI = 11'b00000001000,
        S_SEARCH   = 11'b00000010000,
        S_INDEX    = 11'b00000100000,
        S_UPDATE   = 11'b00001000000,
        S_RCHK     = 11'b00010000000,
        S_RCAP     = 11'b00100000000,
        S_SWEEP    = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] x_count_reg, y_count_reg;
    logic [CNT_W-1:0] nx, ny, nxm1, nym1;

    logic signed [COORD_W-1:0] x_edge_mem [EDGE_DEPTH];
    logic signed [COORD_W-1:0] y_edge_mem [EDGE_DEPTH];
    logic signed [SUM_W-1:0]   cell_mem [CELL_DEPTH];
    logic signed [SUM_W-1:0]   mem_q;

    logic [SLOT_W-1:0]         slot_reg;
    logic signed [COORD_W-1:0] xv_reg, yv_reg, w_reg;

    logic [CNT_W-1:0] x_above_reg, x_below_reg, x_res_reg;
    logic [CNT_W-1:0] y_above_reg, y_below_reg, y_res_reg;
    logic             x_done_reg, y_done_reg, x_out_reg, y_out_reg;
    logic [CNT_W-1:0] x_mid, y_mid;
    logic [EDGE_AW-1:0] x_idx, y_idx;
    logic signed [COORD_W-1:0] x_ev, y_ev;

    logic [CELL_AW-1:0] cell_reg, sweep_reg;
    logic [CELL_CW-1:0] cell_calc;
    logic               x_ok, y_ok, cell_ok;
    logic [2*CNT_W-1:0] active;
    logic               read_ok;

    logic signed [SUM_W-1:0] w_ext, sat_sum;
    logic signed [SUM_W:0]   sum_wide;

    logic                  mem_we, mem_re;
    logic [CELL_AW-1:0]    mem_waddr, mem_raddr;
    logic signed [SUM_W-1:0] mem_wdata;

    logic [STATUS_W-1:0]     res_status_reg;
    logic [CELL_AW-1:0]      res_index_reg;
    logic signed [SUM_W-1:0] res_value_reg;

    logic                    rsp_valid_reg;
    logic [STATUS_W-1:0]     rsp_status_reg;
    logic [CELL_AW-1:0]      rsp_index_reg;
    logic signed [SUM_W-1:0] rsp_value_reg;

    logic cmd_fire, cfg_write, rsp_free;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = {{(PDATA_W-CNT_W){1'b0}},
                        (paddr[2] == REG_Y_COUNT) ? y_count_reg : x_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg <= CNT_W'(2);
            y_count_reg <= CNT_W'(2);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_Y_COUNT)
                y_count_reg <= pwdata[CNT_W-1:0];
            else
                x_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign nx   = (x_count_reg > CNT_W'(EDGE_DEPTH)) ? CNT_W'(EDGE_DEPTH) : x_count_reg;
    assign ny   = (y_count_reg > CNT_W'(EDGE_DEPTH)) ? CNT_W'(EDGE_DEPTH) : y_count_reg;
    assign nxm1 = nx - CNT_W'(1);
    assign nym1 = ny - CNT_W'(1);

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid & cmd.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk)
    begin
        if (cmd_fire && cmd.slot < SLOT_W'(EDGE_DEPTH))
        begin
            if (cmd.func == FN_LOAD_X)
                x_edge_mem[cmd.slot[EDGE_AW-1:0]] <= cmd.edge_value;
            if (cmd.func == FN_LOAD_Y)
                y_edge_mem[cmd.slot[EDGE_AW-1:0]] <= cmd.edge_value;
        end
    end

    assign x_mid = CNT_W'(({1'b0, x_above_reg} + {1'b0, x_below_reg}) >> 1);
    assign y_mid = CNT_W'(({1'b0, y_above_reg} + {1'b0, y_below_reg}) >> 1);

    always_comb
    begin
        case (state_reg)
            S_BOUND_LO:
            begin
                x_idx = '0;
                y_idx = '0;
            end
            S_BOUND_HI:
            begin
                x_idx = nxm1[EDGE_AW-1:0];
                y_idx = nym1[EDGE_AW-1:0];
            end
            default:
            begin
                x_idx = EDGE_AW'(x_mid - CNT_W'(1));
                y_idx = EDGE_AW'(y_mid - CNT_W'(1));
            end
        endcase
    end

    assign x_ev = x_edge_mem[x_idx];
    assign y_ev = y_edge_mem[y_idx];

    assign x_ok = !x_out_reg && (x_res_reg != '0) && (x_res_reg <= nxm1);
    assign y_ok = !y_out_reg && (y_res_reg != '0) && (y_res_reg <= nym1);
    assign cell_calc = CELL_CW'(y_res_reg - CNT_W'(1)) * CELL_CW'(nxm1)
                     + CELL_CW'(x_res_reg - CNT_W'(1));
    assign cell_ok = (cell_calc < CELL_CW'(CELL_DEPTH));

    always_comb
    begin
        if (nx < CNT_W'(2) || ny < CNT_W'(2))
            active = '0;
        else if ((2*CNT_W)'(nxm1) * (2*CNT_W)'(nym1) > (2*CNT_W)'(CELL_DEPTH))
            active = (2*CNT_W)'(CELL_DEPTH);
        else
            active = (2*CNT_W)'(nxm1) * (2*CNT_W)'(nym1);
    end
    assign read_ok = ((2*CNT_W)'(slot_reg) < active);

    assign w_ext    = SUM_W'(w_reg);
    assign sum_wide = {mem_q[SUM_W-1], mem_q} + {w_ext[SUM_W-1], w_ext};
    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sat_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sat_sum = sum_wide[SUM_W-1:0];
    end

    always_comb
    begin
        mem_we    = (state_reg == S_CLEAR) || (state_reg == S_SWEEP)
                 || (state_reg == S_UPDATE);
        mem_waddr = (state_reg == S_UPDATE) ? cell_reg : sweep_reg;
        case (state_reg)
            S_CLEAR:  mem_wdata = '0;
            S_SWEEP:  mem_wdata = w_ext;
            default:  mem_wdata = sat_sum;
        endcase
        mem_re    = (state_reg == S_INDEX) || (state_reg == S_RCHK);
        mem_raddr = (state_reg == S_INDEX) ? cell_calc[CELL_AW-1:0] : slot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= cell_mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (sweep_reg == {CELL_AW{1'b1}})
                    state_next = S_IDLE;
            S_IDLE:
                if (cmd_fire)
                begin
                    case (cmd.func)
                        FN_FILL:    state_next = S_BOUND_LO;
                        FN_READ:    state_next = S_RCHK;
                        FN_SET_ALL: state_next = S_SWEEP;
                        default:    state_next = S_DONE;
                    endcase
                end
            S_BOUND_LO: state_next = S_BOUND_HI;
            S_BOUND_HI: state_next = S_SEARCH;
            S_SEARCH:
                if (x_done_reg && y_done_reg)
                    state_next = S_INDEX;
            S_INDEX:
                state_next = (x_ok && y_ok && cell_ok) ? S_UPDATE : S_DONE;
            S_UPDATE:   state_next = S_DONE;
            S_RCHK:     state_next = read_ok ? S_RCAP : S_DONE;
            S_RCAP:     state_next = S_DONE;
            S_SWEEP:
                if (sweep_reg == {CELL_AW{1'b1}})
                    state_next = S_DONE;
            S_DONE:
                if (rsp_free)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            sweep_reg      <= '0;
            slot_reg       <= '0;
            xv_reg         <= '0;
            yv_reg         <= '0;
            w_reg          <= '0;
            x_above_reg    <= '0;
            x_below_reg    <= '0;
            x_res_reg      <= '0;
            y_above_reg    <= '0;
            y_below_reg    <= '0;
            y_res_reg      <= '0;
            x_done_reg     <= 1'b0;
            y_done_reg     <= 1'b0;
            x_out_reg      <= 1'b0;
            y_out_reg      <= 1'b0;
            cell_reg       <= '0;
            res_status_reg <= ST_DONE;
            res_index_reg  <= '0;
            res_value_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_DONE;
            rsp_index_reg  <= '0;
            rsp_value_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_CLEAR, S_SWEEP:
                    sweep_reg <= sweep_reg + CELL_AW'(1);
                S_IDLE:
                    if (cmd_fire)
                    begin
                        slot_reg       <= cmd.slot;
                        xv_reg         <= cmd.x_coord;
                        yv_reg         <= cmd.y_coord;
                        w_reg          <= cmd.weight;
                        sweep_reg      <= '0;
                        res_index_reg  <= '0;
                        res_value_reg  <= '0;
                        res_status_reg <= ST_DONE;
                        case (cmd.func)
                            FN_LOAD_X, FN_LOAD_Y:
                                if (cmd.slot >= SLOT_W'(EDGE_DEPTH))
                                    res_status_reg <= ST_RANGE;
                            FN_FILL, FN_READ: ;
                            FN_SET_ALL:
                                res_value_reg <= SUM_W'(cmd.weight);
                            default:
                                res_status_reg <= ST_RANGE;
                        endcase
                    end
                S_BOUND_LO:
                begin
                    x_out_reg <= (nx < CNT_W'(2)) || (xv_reg < x_ev);
                    y_out_reg <= (ny < CNT_W'(2)) || (yv_reg < y_ev);
                end
                S_BOUND_HI:
                begin
                    x_out_reg   <= x_out_reg || (xv_reg >= x_ev);
                    y_out_reg   <= y_out_reg || (yv_reg >= y_ev);
                    x_done_reg  <= x_out_reg || (xv_reg >= x_ev);
                    y_done_reg  <= y_out_reg || (yv_reg >= y_ev);
                    x_above_reg <= nx + CNT_W'(1);
                    y_above_reg <= ny + CNT_W'(1);
                    x_below_reg <= '0;
                    y_below_reg <= '0;
                    x_res_reg   <= '0;
                    y_res_reg   <= '0;
                end
                S_SEARCH:
                begin
                    if (!x_done_reg)
                    begin
                        if (x_above_reg - x_below_reg <= CNT_W'(1))
                        begin
                            x_res_reg  <= x_below_reg;
                            x_done_reg <= 1'b1;
                        end
                        else if (xv_reg == x_ev)
                        begin
                            x_res_reg  <= x_mid;
                            x_done_reg <= 1'b1;
                        end
                        else if (xv_reg < x_ev)
                            x_above_reg <= x_mid;
                        else
                            x_below_reg <= x_mid;
                    end
                    if (!y_done_reg)
                    begin
                        if (y_above_reg - y_below_reg <= CNT_W'(1))
                        begin
                            y_res_reg  <= y_below_reg;
                            y_done_reg <= 1'b1;
                        end
                        else if (yv_reg == y_ev)
                        begin
                            y_res_reg  <= y_mid;
                            y_done_reg <= 1'b1;
                        end
                        else if (yv_reg < y_ev)
                            y_above_reg <= y_mid;
                        else
                            y_below_reg <= y_mid;
                    end
                end
                S_INDEX:
                begin
                    cell_reg <= cell_calc[CELL_AW-1:0];
                    if (!(x_ok && y_ok))
                        res_status_reg <= ST_OUTSIDE;
                    else if (!cell_ok)
                        res_status_reg <= ST_RANGE;
                end
                S_UPDATE:
                begin
                    res_index_reg <= cell_reg;
                    res_value_reg <= sat_sum;
                end
                S_RCHK:
                    if (!read_ok)
                        res_status_reg <= ST_RANGE;
                S_RCAP:
                begin
                    res_index_reg <= slot_reg;
                    res_value_reg <= mem_q;
                end
                default: ;
            endcase

            if (state_reg == S_DONE && rsp_free)
            begin
                rsp_valid_reg  <= 1'b1;
                rsp_status_reg <= res_status_reg;
                rsp_index_reg  <= res_index_reg;
                rsp_value_reg  <= res_value_reg;
            end
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.cell_index = rsp_index_reg;
    assign rsp.cell_value = rsp_value_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> !cmd.ready)
        else $error("transfer taken while busy");

    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR || state_reg == S_SWEEP) |-> !cmd.ready)
        else $error("transfer taken during sweep");

    a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.status != ST_UNUSED)
        else $error("unused status code");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_DONE) |-> (rsp.cell_index == '0 && rsp.cell_value == '0))
        else $error("nonzero payload on error");

    a_search_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (x_above_reg <= CNT_W'(EDGE_DEPTH + 1)
                                     && y_above_reg <= CNT_W'(EDGE_DEPTH + 1)))
        else $error("search bound out of range");

endmodule
`default_nettype wire
